FILE: rtl/sync_driven_pixel_capture_assert.svh
// ----------------------------------------------------------------------------
// Sync driven pixel capture assertion macros
// Shared property forms for the capture checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_DRIVEN_PIXEL_CAPTURE_ASSERT_SVH
`define SYNC_DRIVEN_PIXEL_CAPTURE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("capture check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("capture check failed one cycle later");

`endif

FILE: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// Sync driven pixel capture package
// Widths, register indexes, reset values and shared types and functions.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Largest line width or frame height the registers accept.
	localparam int MAX_DIMENSION = 2048;

	localparam int DIM_W      = $clog2(MAX_DIMENSION) + 1;
	localparam int CURSOR_W   = 11;
	localparam int ADDR_W     = 22;
	localparam int CODE_W     = 2;
	localparam int COLOUR_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_W     = $clog2(DIM_W);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] LINE_WIDTH_RESET   = 12'd320;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd200;

	// Pixel captured by the cursor stage, waiting for address and colour work.
	typedef struct packed {
		logic [CURSOR_W-1:0] col;
		logic [CURSOR_W-1:0] row;
		logic [CODE_W-1:0]   red;
		logic [CODE_W-1:0]   green;
		logic [CODE_W-1:0]   blue;
		logic                wr;
	} pix_s1_t;

	// Status of the row wrap unit seen by the cursor stage.
	typedef struct packed {
		logic                busy;
		logic [CURSOR_W-1:0] wrapped_row;
	} rowmod_status_t;

	// Clamp a written dimension into 1 .. MAX_DIMENSION.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// A two-bit code times 85 is the code repeated four times.
	function automatic logic [COLOUR_W-1:0] widen_colour(input logic [CODE_W-1:0] code);
		return {4{code}};
	endfunction

endpackage

FILE: rtl/spc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds line width and frame height, clamped on write.
// ----------------------------------------------------------------------------
module spc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spc_pkg::DIM_W-1:0]      cfg_data,
	output logic [spc_pkg::DIM_W-1:0]      line_width,
	output logic [spc_pkg::DIM_W-1:0]      frame_height,
	output logic                           height_written
);
	import spc_pkg::*;

	logic [DIM_W-1:0] line_width_q;
	logic [DIM_W-1:0] frame_height_q;

	// Writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_WIDTH:   line_width_q   <= clamp_dim(cfg_data);
				REG_FRAME_HEIGHT: frame_height_q <= clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	assign line_width     = line_width_q;
	assign frame_height   = frame_height_q;
	assign height_written = cfg_we && (cfg_index == REG_FRAME_HEIGHT);

endmodule

FILE: rtl/spc_row_mod.sv
// ----------------------------------------------------------------------------
// Row wrap unit
// Computes (row + 1) mod frame height by restoring subtraction, one bit a cycle.
// ----------------------------------------------------------------------------
module spc_row_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spc_pkg::CURSOR_W-1:0]  row_cur,
	input  logic [spc_pkg::DIM_W-1:0]     frame_height,
	output spc_pkg::rowmod_status_t       status
);
	import spc_pkg::*;

	localparam int WIDE_W = 2 * DIM_W - 1;

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [DIM_W-1:0]    rem_q;
	logic [WIDE_W-1:0]   trial;
	logic [WIDE_W-1:0]   rem_wide;
	logic [DIM_W-1:0]    rem_next;

	// Divisor shifted to the current quotient bit.
	always_comb begin
		trial    = WIDE_W'(frame_height) << step_q;
		rem_wide = WIDE_W'(rem_q);
		if (rem_wide >= trial) begin
			rem_next = rem_q - trial[DIM_W-1:0];
		end else begin
			rem_next = rem_q;
		end
	end

	// A new frame height restarts the reduction from the current row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIM_W - 1);
			rem_q  <= DIM_W'(row_cur) + DIM_W'(1);
		end else if (busy_q) begin
			rem_q <= rem_next;
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	assign status.busy        = busy_q;
	assign status.wrapped_row = rem_q[CURSOR_W-1:0];

endmodule

FILE: rtl/spc_cursor.sv
// ----------------------------------------------------------------------------
// Cursor stage
// Detects sync edges, places the pixel and advances the cursor.
// ----------------------------------------------------------------------------
module spc_cursor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          vsync_level,
	input  logic                          hsync_level,
	input  logic [spc_pkg::CODE_W-1:0]    red_bits,
	input  logic [spc_pkg::CODE_W-1:0]    green_bits,
	input  logic [spc_pkg::CODE_W-1:0]    blue_bits,
	input  logic [spc_pkg::DIM_W-1:0]     line_width,
	input  logic [spc_pkg::DIM_W-1:0]     frame_height,
	input  spc_pkg::rowmod_status_t       rowmod,
	input  logic                          advance,
	output logic [spc_pkg::CURSOR_W-1:0]  row_cur,
	output logic                          s1_valid,
	output spc_pkg::pix_s1_t              s1_pix
);
	import spc_pkg::*;

	logic [CURSOR_W-1:0] column_q;
	logic [CURSOR_W-1:0] row_q;
	logic                last_vsync_q;
	logic                last_hsync_q;
	logic                valid_s1;
	pix_s1_t             pix_s1;

	logic                in_fire;
	logic                v_rise;
	logic                h_rise;
	logic [CURSOR_W-1:0] col_now;
	logic [CURSOR_W-1:0] row_now;
	logic [CURSOR_W-1:0] row_inc_cur;
	logic [CURSOR_W-1:0] row_inc_now;
	logic [DIM_W-1:0]    col_plus;
	logic [CURSOR_W-1:0] col_new;
	logic [CURSOR_W-1:0] row_new;

	// Step a row that lies inside the frame, wrapping at the frame height.
	function automatic logic [CURSOR_W-1:0] step_row(
		input logic [CURSOR_W-1:0] r,
		input logic [DIM_W-1:0]    h
	);
		logic [DIM_W-1:0] p;
		p = DIM_W'(r) + DIM_W'(1);
		return (p == h) ? '0 : p[CURSOR_W-1:0];
	endfunction

	assign in_fire = in_valid && in_ready;
	assign in_ready = !rowmod.busy && (!valid_s1 || advance);

	// Placement of this transaction's pixel.
	always_comb begin
		v_rise = vsync_level && !last_vsync_q;
		h_rise = hsync_level && !last_hsync_q;

		// A row left outside the frame by a height change wraps through the unit.
		if (DIM_W'(row_q) < frame_height) begin
			row_inc_cur = step_row(row_q, frame_height);
		end else begin
			row_inc_cur = rowmod.wrapped_row;
		end

		if (v_rise) begin
			col_now = '0;
			row_now = '0;
		end else if (h_rise) begin
			col_now = '0;
			row_now = row_inc_cur;
		end else begin
			col_now = column_q;
			row_now = row_q;
		end

		// After a sync edge the row is inside the frame.
		if (v_rise || h_rise) begin
			row_inc_now = step_row(row_now, frame_height);
		end else begin
			row_inc_now = row_inc_cur;
		end

		// Advance the column and wrap at the end of the line.
		col_plus = DIM_W'(col_now) + DIM_W'(1);
		if (col_plus >= line_width) begin
			col_new = '0;
			row_new = row_inc_now;
		end else begin
			col_new = col_plus[CURSOR_W-1:0];
			row_new = row_now;
		end
	end

	// Cursor state and sync history move with every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			last_vsync_q <= 1'b0;
			last_hsync_q <= 1'b0;
		end else if (in_fire) begin
			column_q     <= col_new;
			row_q        <= row_new;
			last_vsync_q <= vsync_level;
			last_hsync_q <= hsync_level;
		end
	end

	// Stage register toward the address stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1.col   <= col_now;
			pix_s1.row   <= row_now;
			pix_s1.red   <= red_bits;
			pix_s1.green <= green_bits;
			pix_s1.blue  <= blue_bits;
			pix_s1.wr    <= (DIM_W'(col_now) < line_width) &&
			                (DIM_W'(row_now) < frame_height);
		end
	end

	assign row_cur  = row_q;
	assign s1_valid = valid_s1;
	assign s1_pix   = pix_s1;

endmodule

FILE: rtl/spc_pixel_out.sv
// ----------------------------------------------------------------------------
// Address and colour stage
// Forms the linear address and widened colours into the result register.
// ----------------------------------------------------------------------------
module spc_pixel_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s1_valid,
	input  spc_pkg::pix_s1_t              s1_pix,
	input  logic [spc_pkg::DIM_W-1:0]     line_width,
	output logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spc_pkg::CURSOR_W-1:0]  pixel_column,
	output logic [spc_pkg::CURSOR_W-1:0]  pixel_row,
	output logic [spc_pkg::ADDR_W-1:0]    pixel_address,
	output logic [spc_pkg::COLOUR_W-1:0]  red_value,
	output logic [spc_pkg::COLOUR_W-1:0]  green_value,
	output logic [spc_pkg::COLOUR_W-1:0]  blue_value
);
	import spc_pkg::*;

	localparam int PROD_W = CURSOR_W + DIM_W;

	logic                out_valid_q;
	logic [CURSOR_W-1:0] column_q;
	logic [CURSOR_W-1:0] row_q;
	logic [ADDR_W-1:0]   address_q;
	logic [COLOUR_W-1:0] red_q;
	logic [COLOUR_W-1:0] green_q;
	logic [COLOUR_W-1:0] blue_q;
	logic [PROD_W-1:0]   address_full;

	// The result register frees up when empty or when its transaction is taken.
	assign advance = !out_valid_q || out_ready;

	assign address_full = PROD_W'(s1_pix.row) * PROD_W'(line_width) + PROD_W'(s1_pix.col);

	// Pixels outside the frame are dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid && s1_pix.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			column_q  <= s1_pix.col;
			row_q     <= s1_pix.row;
			address_q <= address_full[ADDR_W-1:0];
			red_q     <= widen_colour(s1_pix.red);
			green_q   <= widen_colour(s1_pix.green);
			blue_q    <= widen_colour(s1_pix.blue);
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_column  = column_q;
	assign pixel_row     = row_q;
	assign pixel_address = address_q;
	assign red_value     = red_q;
	assign green_value   = green_q;
	assign blue_value    = blue_q;

endmodule

FILE: rtl/sync_driven_pixel_capture.sv
// ----------------------------------------------------------------------------
// Sync driven pixel capture
// Turns sync levels and 2-bit colour pins into frame buffer writes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | vsync, hsync, red, green, blue pins
//  out      | out_valid / out_ready  | column, row, address, 8-bit colours
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// One transaction is taken per cycle while in_ready is high; its write passes
// through the cursor stage register and then the result register to the output.
// Ticks outside the frame produce no output transaction.
// A frame height write holds in_ready low while the row wrap unit reduces
// the current row against the new height.
// A stalled output holds the result register; the cursor stage keeps one
// more transaction before in_ready falls.
// ----------------------------------------------------------------------------
module sync_driven_pixel_capture (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spc_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          vsync_level,
	input  logic                          hsync_level,
	input  logic [spc_pkg::CODE_W-1:0]    red_bits,
	input  logic [spc_pkg::CODE_W-1:0]    green_bits,
	input  logic [spc_pkg::CODE_W-1:0]    blue_bits,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spc_pkg::CURSOR_W-1:0]  pixel_column,
	output logic [spc_pkg::CURSOR_W-1:0]  pixel_row,
	output logic [spc_pkg::ADDR_W-1:0]    pixel_address,
	output logic [spc_pkg::COLOUR_W-1:0]  red_value,
	output logic [spc_pkg::COLOUR_W-1:0]  green_value,
	output logic [spc_pkg::COLOUR_W-1:0]  blue_value
);
	import spc_pkg::*;

	logic [DIM_W-1:0]    line_width;
	logic [DIM_W-1:0]    frame_height;
	logic                height_written;
	logic [CURSOR_W-1:0] row_cur;
	rowmod_status_t      rowmod;
	logic                advance;
	logic                s1_valid;
	pix_s1_t             s1_pix;

	spc_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.line_width     (line_width),
		.frame_height   (frame_height),
		.height_written (height_written)
	);

	spc_row_mod u_row_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (height_written),
		.row_cur      (row_cur),
		.frame_height (frame_height),
		.status       (rowmod)
	);

	spc_cursor u_cursor (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.vsync_level  (vsync_level),
		.hsync_level  (hsync_level),
		.red_bits     (red_bits),
		.green_bits   (green_bits),
		.blue_bits    (blue_bits),
		.line_width   (line_width),
		.frame_height (frame_height),
		.rowmod       (rowmod),
		.advance      (advance),
		.row_cur      (row_cur),
		.s1_valid     (s1_valid),
		.s1_pix       (s1_pix)
	);

	spc_pixel_out u_pixel_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.s1_valid      (s1_valid),
		.s1_pix        (s1_pix),
		.line_width    (line_width),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_column  (pixel_column),
		.pixel_row     (pixel_row),
		.pixel_address (pixel_address),
		.red_value     (red_value),
		.green_value   (green_value),
		.blue_value    (blue_value)
	);

endmodule

FILE: rtl/spc_checker.sv
// ----------------------------------------------------------------------------
// Sync driven pixel capture checker
// Port level checks on the capture block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sync_driven_pixel_capture_assert.svh"

module spc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [spc_pkg::CURSOR_W-1:0]  pixel_column,
	input  logic [spc_pkg::CURSOR_W-1:0]  pixel_row,
	input  logic [spc_pkg::ADDR_W-1:0]    pixel_address,
	input  logic [spc_pkg::COLOUR_W-1:0]  red_value,
	input  logic [spc_pkg::COLOUR_W-1:0]  green_value,
	input  logic [spc_pkg::COLOUR_W-1:0]  blue_value
);
	import spc_pkg::*;

	// A stalled output transaction keeps its place and its address.
	`SPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_address))

	// Widened colours are a two-bit code repeated.
	`SPC_ASSERT_NOW(a_colour_form, clk, arst_n, out_valid, (red_value == {4{red_value[1:0]}}) && (green_value == {4{green_value[1:0]}}) && (blue_value == {4{blue_value[1:0]}}))

	// With a line width of at least one the address covers row plus column.
	`SPC_ASSERT_NOW(a_addr_floor, clk, arst_n, out_valid, ADDR_W'(pixel_row) + ADDR_W'(pixel_column) <= pixel_address)

	// A frame height write stops intake while the row is reduced.
	`SPC_ASSERT_NEXT(a_height_stall, clk, arst_n, cfg_we && (cfg_index == REG_FRAME_HEIGHT), !in_ready)

endmodule

bind sync_driven_pixel_capture spc_checker u_spc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.pixel_column  (pixel_column),
	.pixel_row     (pixel_row),
	.pixel_address (pixel_address),
	.red_value     (red_value),
	.green_value   (green_value),
	.blue_value    (blue_value)
);
